// ===== src/twc_pkg.sv =====
// twc_pkg: sizes, channel widths and controller/datapath interface types
// for the trie word counter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package twc_pkg;

  localparam int NODE_COUNT = 4096;
  localparam int COUNT_BITS = 16;
  localparam int ALPHABET   = 26;

  localparam int NODE_W   = $clog2(NODE_COUNT);
  localparam int LETTER_W = 5;
  localparam int SLOT_W   = $clog2(NODE_COUNT * ALPHABET);
  localparam int STATUS_W = 2;

  localparam int IN_DATA_W  = ((LETTER_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((NODE_W + COUNT_BITS + 7) / 8) * 8;

  localparam logic [STATUS_W-1:0] ST_COUNTED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DROPPED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic accept;    // latch request fields
    logic rd_link;   // read child link for (cursor, letter)
    logic rd_rec;    // read node record of the link target
    logic resolve;   // follow, allocate or start dropping
    logic rd_cnt;    // read word count of cursor node
    logic upd_cnt;   // increment and write back count
    logic load_out;  // move result into output register
    logic clr_word;  // back to root, end of word
  } twc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic walk_ok;   // incoming letter is walked: valid code, word not dropped
    logic word_end;  // latched end-of-word flag
    logic out_free;  // output register can take a result
  } twc_sts_t;

endpackage

`default_nettype wire

// ===== src/twc_ctrl.sv =====
// twc_ctrl: sequencer for the trie walk, count update and result hand-off.
// Depends on twc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module twc_ctrl
  import twc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  input  wire logic     in_tlast,
  output logic          in_tready,
  input  wire twc_sts_t sts,
  output twc_cmd_t      cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LINK  = 6'b000010,
    S_CHECK = 6'b000100,
    S_CNT   = 6'b001000,
    S_INC   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (sts.walk_ok) begin
            cmd.rd_link = 1'b1;
            state_nxt   = S_LINK;
          end else if (in_tlast) begin
            state_nxt = S_CNT;
          end
        end
      end
      S_LINK: begin
        cmd.rd_rec = 1'b1;
        state_nxt  = S_CHECK;
      end
      S_CHECK: begin
        cmd.resolve = 1'b1;
        state_nxt   = sts.word_end ? S_CNT : S_IDLE;
      end
      S_CNT: begin
        cmd.rd_cnt = 1'b1;
        state_nxt  = S_INC;
      end
      S_INC: begin
        cmd.upd_cnt = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.clr_word = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/twc_datapath.sv =====
// twc_datapath: child-link, node-record and count memories, walk registers
// and the output register. Depends on twc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module twc_datapath
  import twc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [LETTER_W-1:0]   in_letter,
  input  wire logic                  in_word_end,
  input  wire twc_cmd_t              cmd,
  output twc_sts_t                   sts,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [NODE_W-1:0]          out_node,
  output logic [COUNT_BITS-1:0]      out_total,
  output logic [STATUS_W-1:0]        out_status
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [NODE_W-1:0]     LAST_NODE = NODE_W'(NODE_COUNT - 1);

  // Memories. Link entries are trusted only if the target node's record
  // points back at (node, letter), so no clearing pass is needed.
  logic [NODE_W-1:0]          link_mem [NODE_COUNT*ALPHABET];
  logic [NODE_W+LETTER_W-1:0] rec_mem  [NODE_COUNT];
  logic [COUNT_BITS-1:0]      cnt_mem  [NODE_COUNT];

  logic [NODE_W-1:0]          link_q;
  logic [NODE_W+LETTER_W-1:0] rec_q;
  logic [COUNT_BITS-1:0]      cnt_q;

  logic [LETTER_W-1:0]   letter_r;
  logic                  word_end_r;
  logic [SLOT_W-1:0]     slot_r;
  logic [NODE_W-1:0]     cursor_r;
  logic [NODE_W-1:0]     last_r;
  logic                  drop_r;
  logic                  root_ok_r;
  logic [NODE_W-1:0]     res_node_r;
  logic [COUNT_BITS-1:0] res_total_r;
  logic [STATUS_W-1:0]   res_status_r;
  logic                  out_valid_r;
  logic [NODE_W-1:0]     out_node_r;
  logic [COUNT_BITS-1:0] out_total_r;
  logic [STATUS_W-1:0]   out_status_r;

  logic [SLOT_W-1:0]     slot_addr;
  bit                    hit;        // never-written entries count as a miss
  logic                  can_alloc;
  logic [NODE_W-1:0]     new_node;
  logic [COUNT_BITS-1:0] cnt_cur;
  logic [COUNT_BITS-1:0] total_nxt;
  logic                  alloc_wr;

  assign slot_addr = SLOT_W'(cursor_r) * SLOT_W'(ALPHABET) + SLOT_W'(in_letter);

  assign hit = (link_q != '0) && (link_q <= last_r) &&
               (rec_q == {cursor_r, letter_r});
  assign can_alloc = (last_r != LAST_NODE);
  assign new_node  = last_r + NODE_W'(1);
  assign alloc_wr  = cmd.resolve && !hit && can_alloc;

  assign cnt_cur   = (cursor_r == '0 && !root_ok_r) ? '0 : cnt_q;
  assign total_nxt = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + COUNT_BITS'(1);

  assign sts.walk_ok  = !drop_r && (in_letter < LETTER_W'(ALPHABET));
  assign sts.word_end = word_end_r;
  assign sts.out_free = !out_valid_r || out_tready;

  // memories
  always_ff @(posedge clk) begin
    if (cmd.rd_link) begin
      link_q <= link_mem[slot_addr];
    end
    if (alloc_wr) begin
      link_mem[slot_r] <= new_node;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_rec) begin
      rec_q <= rec_mem[link_q];
    end
    if (alloc_wr) begin
      rec_mem[new_node] <= {cursor_r, letter_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_cnt) begin
      cnt_q <= cnt_mem[cursor_r];
    end
    if (alloc_wr) begin
      cnt_mem[new_node] <= '0;
    end else if (cmd.upd_cnt && !drop_r) begin
      cnt_mem[cursor_r] <= total_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      letter_r   <= in_letter;
      word_end_r <= in_word_end;
      slot_r     <= slot_addr;
    end
    if (cmd.upd_cnt) begin
      if (drop_r) begin
        res_node_r   <= '0;
        res_total_r  <= '0;
        res_status_r <= ST_DROPPED;
      end else begin
        res_node_r   <= cursor_r;
        res_total_r  <= total_nxt;
        res_status_r <= (total_nxt == COUNT_MAX) ? ST_SATURATED : ST_COUNTED;
      end
    end
    if (cmd.load_out) begin
      out_node_r   <= res_node_r;
      out_total_r  <= res_total_r;
      out_status_r <= res_status_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r    <= '0;
      last_r      <= '0;
      drop_r      <= 1'b0;
      root_ok_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.resolve) begin
        if (hit) begin
          cursor_r <= link_q;
        end else if (can_alloc) begin
          cursor_r <= new_node;
          last_r   <= new_node;
        end else begin
          drop_r <= 1'b1;
        end
      end
      if (cmd.upd_cnt && !drop_r && cursor_r == '0) begin
        root_ok_r <= 1'b1;
      end
      if (cmd.clr_word) begin
        cursor_r <= '0;
        drop_r   <= 1'b0;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_node   = out_node_r;
  assign out_total  = out_total_r;
  assign out_status = out_status_r;

endmodule

`default_nettype wire

// ===== src/trie_word_counter.sv =====
// trie_word_counter: top level, stream ports around twc_ctrl and twc_datapath.
// Depends on twc_pkg, twc_ctrl, twc_datapath.
//
//   channel | direction | tdata (low bit up)           | tlast    | tuser
//   in_     | request   | letter[4:0]                  | word_end | -
//   out_    | result    | node_number[11:0], word_total | -        | status[1:0]
//
// A letter goes through link read, node record read, then follow or allocate;
// an unused letter code, or any letter of a word being dropped, skips these steps.
// The last letter of a word adds the count read-modify-write and the
// output load; the block then waits only if the previous result is still unread.
// No clearing pass after reset: links are validated against per-node records and
// the allocation count, so the block is ready straight out of reset.
// The next request is taken while a result sits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module trie_word_counter
  import twc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // letter
  input  wire logic                  in_tlast,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // node_number, word_total
  output logic [STATUS_W-1:0]        out_tuser   // status
);

  twc_cmd_t              cmd;
  twc_sts_t              sts;
  logic [NODE_W-1:0]     out_node;
  logic [COUNT_BITS-1:0] out_total;

  twc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  twc_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_letter   (in_tdata[LETTER_W-1:0]),
    .in_word_end (in_tlast),
    .cmd         (cmd),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_node    (out_node),
    .out_total   (out_total),
    .out_status  (out_tuser)
  );

  assign out_tdata = OUT_DATA_W'({out_total, out_node});

endmodule

`default_nettype wire

// ===== tb/tb_trie_word_counter.sv =====
// tb_trie_word_counter: self-checking bench for trie_word_counter. A letter stream
// drives the block; a local trie predicts each word's node, count and status.
// Depends on twc_pkg and trie_word_counter.
`timescale 1ns / 1ps

module tb_trie_word_counter;
  import twc_pkg::*;

  localparam int COUNT_TOP  = (1 << COUNT_BITS) - 1;
  localparam int QUIET_MAX  = 4000;
  localparam int SETTLE_CYC = 20;

  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic                word_end;
  } letter_req_t;

  typedef struct packed {
    logic [NODE_W-1:0]     node;
    logic [COUNT_BITS-1:0] total;
    logic [STATUS_W-1:0]   status;
  } word_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;

  letter_req_t  letter_queue[$];
  word_result_t word_results[$];
  int           errors = 0;
  int           quiet = 0;
  logic         steady = 1'b0;

  // trie shadow
  logic [NODE_W-1:0]     links[NODE_COUNT*ALPHABET];
  logic [COUNT_BITS-1:0] counts[NODE_COUNT];
  int                    allocated;
  int                    cursor;
  logic                  dropping;

  trie_word_counter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #1 clk = ~clk;

  function automatic void trace_letter(logic [LETTER_W-1:0] letter, logic word_end);
    int           slot;
    int           nxt;
    word_result_t r;
    if (!dropping && letter < ALPHABET) begin
      slot = cursor * ALPHABET + int'(letter);
      nxt = int'(links[slot]);
      if (nxt == 0) begin
        if (allocated + 1 < NODE_COUNT) begin
          allocated++;
          links[slot] = NODE_W'(allocated);
          nxt = allocated;
        end else begin
          dropping = 1'b1;
        end
      end
      if (!dropping) cursor = nxt;
    end
    if (word_end) begin
      if (dropping) begin
        r = '{node: '0, total: '0, status: ST_DROPPED};
      end else begin
        r.node = NODE_W'(cursor);
        r.total = counts[cursor];
        if (r.total != COUNT_BITS'(COUNT_TOP)) r.total++;
        counts[cursor] = r.total;
        r.status = (r.total == COUNT_BITS'(COUNT_TOP)) ? ST_SATURATED : ST_COUNTED;
      end
      word_results.insert(word_results.size(), r);
      cursor = 0;
      dropping = 1'b0;
    end
  endfunction

  function automatic logic idle_now();
    return !steady && ($urandom_range(0, 99) < 9);
  endfunction

  function automatic void push_letter(int letter, logic word_end);
    letter_queue.insert(letter_queue.size(),
                        '{letter: LETTER_W'(letter), word_end: word_end});
  endfunction

  // noise: percent of letters drawn from the unused codes 26..31
  function automatic void push_word(int len, int span, int noise);
    int l;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < noise) l = $urandom_range(ALPHABET, 31);
      else l = $urandom_range(0, span);
      push_letter(l, i == len - 1);
    end
  endfunction

  task automatic drain();
    while (letter_queue.size() != 0 || in_tvalid || word_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic random_words(int n_items);
    int start;
    int span;
    start = letter_queue.size();
    while (letter_queue.size() - start < n_items) begin
      span = ($urandom_range(0, 3) == 0) ? ALPHABET - 1 : $urandom_range(1, 4);
      push_word($urandom_range(1, 6), span, 6);
    end
  endtask

  // driver
  always @(posedge clk) begin : drive_letters
    letter_req_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) trace_letter(in_tdata[LETTER_W-1:0], in_tlast);
      if (!in_tvalid || in_tready) begin
        if (letter_queue.size() != 0 && !idle_now()) begin
          nxt = letter_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= IN_DATA_W'(nxt.letter);
          in_tlast <= nxt.word_end;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : check_results
    word_result_t got;
    word_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.node = out_tdata[NODE_W-1:0];
      got.total = out_tdata[NODE_W +: COUNT_BITS];
      got.status = out_tuser;
      if (word_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result node %0d total %0d status %0d",
                 $time, got.node, got.total, got.status);
      end else begin
        want = word_results.pop_front();
        if (got.node !== want.node || got.total !== want.total ||
            got.status !== want.status) begin
          errors++;
          $display({"%0t: expected node %0d total %0d status %0d,",
                    " got node %0d total %0d status %0d"},
                   $time, want.node, want.total, want.status,
                   got.node, got.total, got.status);
        end
      end
    end
    out_tready <= rst_n && !idle_now();
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_MAX) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    foreach (links[i]) links[i] = '0;
    foreach (counts[i]) counts[i] = '0;
    allocated = 0;
    cursor = 0;
    dropping = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    push_letter(0, 1'b1);
    push_letter(0, 1'b1);
    push_letter(25, 1'b1);
    push_letter(31, 1'b1);             // empty word lands on the root
    push_letter(26, 1'b1);
    push_letter(1, 1'b0);
    push_letter(27, 1'b0);             // unused code mid-word
    push_letter(2, 1'b1);
    push_letter(1, 1'b0);
    push_letter(2, 1'b1);
    for (int l = 25; l >= 20; l--) push_letter(l, l == 20);
    push_letter(16, 1'b1);
    push_letter(15, 1'b1);
    push_letter(0, 1'b0);
    push_letter(30, 1'b1);             // end flag on an ignored code
    drain();

    random_words(475);
    drain();
    steady = 1'b1;
    random_words(475);
    drain();
    steady = 1'b0;

    repeat (SETTLE_CYC) @(posedge clk);
    if (errors == 0 && word_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/twc_pkg.sv
src/twc_ctrl.sv
src/twc_datapath.sv
src/trie_word_counter.sv
tb/tb_trie_word_counter.sv
